FILE: rtl/swct_pkg.sv
// Shared types, constants and a helper function of the stopwatch / count-down timer.
// Used by swct_ctrl, swct_dp and stopwatch_countdown_timer; depends on nothing.
package swct_pkg;

	// Timebase and widths.
	localparam int TICKS_PER_SECOND = 1000;
	localparam int TIME_WIDTH       = 64;
	localparam int NOW_W            = 64;
	localparam int LOAD_W           = 32;
	localparam int FUNC_W           = 3;
	localparam int VAL_W            = 32;
	localparam int MODE_W           = 2;
	localparam int UNIT_W           = 2;

	// Divisor width: wide enough for the largest unit divisor.
	localparam int DIV_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int MUL_W  = LOAD_W + DIV_W;
	localparam int CNT_W  = $clog2(VAL_W + 1);
	localparam int DIV_MS = ((TICKS_PER_SECOND / 1000) == 0) ? 1 : (TICKS_PER_SECOND / 1000);

	// Input transfer layout.
	localparam int FUNC_LSB    = 0;
	localparam int NOW_LSB     = FUNC_LSB + FUNC_W;
	localparam int LOAD_LSB    = NOW_LSB + NOW_W;
	localparam int IN_W        = LOAD_LSB + LOAD_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

	// Output transfer layout.
	localparam int MODE_LSB    = 0;
	localparam int SHOWN_LSB   = MODE_LSB + MODE_W;
	localparam int VVALID_BIT  = SHOWN_LSB + VAL_W;
	localparam int WRAP_BIT    = VVALID_BIT + 1;
	localparam int ACC_BIT     = WRAP_BIT + 1;
	localparam int OUT_W       = ACC_BIT + 1;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_DOWN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT  = 1'd1;

	// Unit codes.
	localparam logic [UNIT_W-1:0] UNIT_TICKS = 2'd0;
	localparam logic [UNIT_W-1:0] UNIT_MS    = 2'd1;
	localparam logic [UNIT_W-1:0] UNIT_S     = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_RESET = 3'd0,
		FN_START = 3'd1,
		FN_PAUSE = 3'd2,
		FN_CONT  = 3'd3,
		FN_LOAD  = 3'd4,
		FN_READ  = 3'd5
	} func_t;

	typedef enum logic [MODE_W-1:0] {
		RS_READY   = 2'd0,
		RS_LOADED  = 2'd1,
		RS_RUNNING = 2'd2,
		RS_PAUSED  = 2'd3
	} run_state_t;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_START_NOW  = 4'd1,
		OP_START_ADD  = 4'd2,
		OP_PAUSE      = 4'd3,
		OP_PAUSE_DIFF = 4'd4,
		OP_PAUSE_ACC  = 4'd5,
		OP_LOAD       = 4'd6,
		OP_START_DIFF = 4'd7,
		OP_TICKS_UP   = 4'd8,
		OP_TARGET     = 4'd9,
		OP_TICKS_DOWN = 4'd10
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_STEP2 = 5'b00100,
		S_DIV   = 5'b01000,
		S_FIN   = 5'b10000
	} ctrl_state_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic now_lt_start;
		logic now_lt_pause;
		logic div_done;
	} dp_stat_t;

	typedef struct packed {
		run_state_t mode;
		logic       value_valid;
		logic       wrapped;
		logic       accepted;
	} ctrl_res_t;

	// Divisor for a reading, also the multiplier for a load.
	function automatic logic [DIV_W-1:0] unit_divisor(input logic [UNIT_W-1:0] unit);
		logic [DIV_W-1:0] d;
		case (unit)
			UNIT_MS: d = DIV_W'(DIV_MS);
			UNIT_S:  d = DIV_W'(TICKS_PER_SECOND);
			default: d = DIV_W'(1);
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/swct_ctrl.sv
// Sequencing controller of the timer: command decode, run state and result flags.
// Uses swct_pkg; drives swct_dp through a command struct and reads its status.
module swct_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [swct_pkg::FUNC_W-1:0]     func,
	input  logic                            count_down,
	input  swct_pkg::dp_stat_t              stat,
	input  logic                            out_free,
	output swct_pkg::dp_cmd_t               cmd,
	output swct_pkg::ctrl_res_t             res,
	output logic                            res_load
);

	swct_pkg::ctrl_state_t state_q, state_d;
	swct_pkg::run_state_t  run_q, run_d;
	swct_pkg::dp_op_t      step2_q, step2_d;
	logic [swct_pkg::FUNC_W-1:0] func_q;
	logic acc_q, acc_d, wrap_q, wrap_d, vld_q, vld_d;

	always_comb begin
		state_d  = state_q;
		run_d    = run_q;
		step2_d  = step2_q;
		acc_d    = acc_q;
		wrap_d   = wrap_q;
		vld_d    = vld_q;
		cmd      = '{capture: 1'b0, op: swct_pkg::OP_NONE};
		res_load = 1'b0;
		case (state_q)
			swct_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					acc_d       = 1'b0;
					wrap_d      = 1'b0;
					vld_d       = 1'b0;
					state_d     = swct_pkg::S_EXEC;
				end
			end
			swct_pkg::S_EXEC: begin
				state_d = swct_pkg::S_FIN;
				case (func_q)
					swct_pkg::FN_RESET: begin
						run_d = swct_pkg::RS_READY;
						acc_d = 1'b1;
					end
					swct_pkg::FN_START: begin
						if (!count_down && run_q == swct_pkg::RS_READY) begin
							cmd.op = swct_pkg::OP_START_NOW;
							run_d  = swct_pkg::RS_RUNNING;
							acc_d  = 1'b1;
						end else if (count_down && run_q == swct_pkg::RS_LOADED) begin
							cmd.op = swct_pkg::OP_START_ADD;
							run_d  = swct_pkg::RS_RUNNING;
							acc_d  = 1'b1;
						end
					end
					swct_pkg::FN_PAUSE: begin
						if (run_q == swct_pkg::RS_RUNNING) begin
							cmd.op = swct_pkg::OP_PAUSE;
							run_d  = swct_pkg::RS_PAUSED;
							acc_d  = 1'b1;
						end
					end
					swct_pkg::FN_CONT: begin
						if (run_q == swct_pkg::RS_PAUSED) begin
							acc_d = 1'b1;
							if (stat.now_lt_pause) begin
								wrap_d = 1'b1;
								run_d  = swct_pkg::RS_READY;
							end else begin
								cmd.op  = swct_pkg::OP_PAUSE_DIFF;
								step2_d = swct_pkg::OP_PAUSE_ACC;
								run_d   = swct_pkg::RS_RUNNING;
								state_d = swct_pkg::S_STEP2;
							end
						end
					end
					swct_pkg::FN_LOAD: begin
						if (count_down && run_q == swct_pkg::RS_READY) begin
							cmd.op = swct_pkg::OP_LOAD;
							run_d  = swct_pkg::RS_LOADED;
							acc_d  = 1'b1;
						end
					end
					swct_pkg::FN_READ: begin
						acc_d = 1'b1;
						if (run_q == swct_pkg::RS_RUNNING) begin
							if (!count_down) begin
								if (stat.now_lt_start) begin
									wrap_d = 1'b1;
									run_d  = swct_pkg::RS_READY;
								end else begin
									cmd.op  = swct_pkg::OP_START_DIFF;
									step2_d = swct_pkg::OP_TICKS_UP;
									vld_d   = 1'b1;
									state_d = swct_pkg::S_STEP2;
								end
							end else begin
								cmd.op  = swct_pkg::OP_TARGET;
								step2_d = swct_pkg::OP_TICKS_DOWN;
								vld_d   = 1'b1;
								state_d = swct_pkg::S_STEP2;
							end
						end
					end
					default: begin
					end
				endcase
			end
			swct_pkg::S_STEP2: begin
				cmd.op  = step2_q;
				state_d = (step2_q == swct_pkg::OP_PAUSE_ACC) ? swct_pkg::S_FIN
				                                              : swct_pkg::S_DIV;
			end
			swct_pkg::S_DIV: begin
				if (stat.div_done) begin
					state_d = swct_pkg::S_FIN;
				end
			end
			swct_pkg::S_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = swct_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swct_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swct_pkg::S_IDLE;
			run_q   <= swct_pkg::RS_READY;
			step2_q <= swct_pkg::OP_NONE;
			acc_q   <= 1'b0;
			wrap_q  <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			run_q   <= run_d;
			step2_q <= step2_d;
			acc_q   <= acc_d;
			wrap_q  <= wrap_d;
			vld_q   <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
		end
	end

	assign in_ready = (state_q == swct_pkg::S_IDLE);
	assign res      = '{mode: run_q, value_valid: vld_q, wrapped: wrap_q, accepted: acc_q};

endmodule

FILE: rtl/swct_dp.sv
// Datapath of the timer: time registers, one wide adder step per cycle,
// the load multiplier and a bit-serial divider. Uses swct_pkg; driven by swct_ctrl.
module swct_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swct_pkg::dp_cmd_t                cmd,
	input  logic [swct_pkg::NOW_W-1:0]       now,
	input  logic [swct_pkg::LOAD_W-1:0]      load_value,
	input  logic [swct_pkg::UNIT_W-1:0]      time_unit,
	output swct_pkg::dp_stat_t               stat,
	output logic [swct_pkg::VAL_W-1:0]       quotient
);

	localparam int TW = swct_pkg::TIME_WIDTH;
	localparam int DW = swct_pkg::DIV_W;
	localparam int VW = swct_pkg::VAL_W;
	localparam int MW = swct_pkg::MUL_W;

	logic [TW-1:0] now_q, start_q, pause_q, paused_q, diff_q;
	logic [swct_pkg::LOAD_W-1:0] load_q;
	logic [VW-1:0] dvd_q;
	logic [DW-1:0] rem_q;
	logic [swct_pkg::CNT_W-1:0] cnt_q;

	logic [DW-1:0]    divisor;
	logic [MW-1:0]    prod;
	logic [TW+MW-1:0] prod_ext;
	logic [TW-1:0]    ticks_up, ticks_down;
	logic [DW:0]      trial, trial_sub;
	logic             trial_ge;

	assign divisor   = swct_pkg::unit_divisor(time_unit);
	assign prod      = MW'(load_q) * MW'(divisor);
	assign prod_ext  = {{TW{1'b0}}, prod};
	assign ticks_up  = diff_q - paused_q;
	assign ticks_down = diff_q - now_q;

	// One restoring division step: shift in the next dividend bit and try the subtraction.
	assign trial     = {rem_q, dvd_q[VW-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign trial_ge  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			pause_q  <= '0;
			paused_q <= '0;
			cnt_q    <= '0;
		end else begin
			case (cmd.op)
				swct_pkg::OP_START_NOW: begin
					start_q  <= now_q;
					paused_q <= '0;
				end
				swct_pkg::OP_START_ADD: begin
					start_q  <= start_q + now_q;
					paused_q <= '0;
				end
				swct_pkg::OP_PAUSE:     pause_q  <= now_q;
				swct_pkg::OP_PAUSE_ACC: paused_q <= paused_q + diff_q;
				swct_pkg::OP_LOAD:      start_q  <= prod_ext[TW-1:0];
				default: begin
				end
			endcase
			if (cmd.op == swct_pkg::OP_TICKS_UP || cmd.op == swct_pkg::OP_TICKS_DOWN) begin
				cnt_q <= swct_pkg::CNT_W'(VW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q  <= now[TW-1:0];
			load_q <= load_value;
		end
		case (cmd.op)
			swct_pkg::OP_PAUSE_DIFF: diff_q <= now_q - pause_q;
			swct_pkg::OP_START_DIFF: diff_q <= now_q - start_q;
			swct_pkg::OP_TARGET:     diff_q <= start_q + paused_q;
			swct_pkg::OP_TICKS_UP: begin
				dvd_q <= ticks_up[VW-1:0];
				rem_q <= '0;
			end
			swct_pkg::OP_TICKS_DOWN: begin
				// Past zero a count-down reads nothing left.
				dvd_q <= (now_q > diff_q) ? '0 : ticks_down[VW-1:0];
				rem_q <= '0;
			end
			default: begin
				if (cnt_q != '0) begin
					rem_q <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
					dvd_q <= {dvd_q[VW-2:0], trial_ge};
				end
			end
		endcase
	end

	assign stat.now_lt_start = (now_q < start_q);
	assign stat.now_lt_pause = (now_q < pause_q);
	assign stat.div_done     = (cnt_q == '0);
	assign quotient          = dvd_q;

endmodule

FILE: rtl/stopwatch_countdown_timer.sv
// Top level of the stopwatch / count-down timer: configuration registers, output register
// and the assembly of controller and datapath. Uses swct_pkg, swct_ctrl and swct_dp.
//
// Each command arrives as one transfer on the s_ channel and produces exactly one result
// transfer on the m_ channel, in order. The user must write configuration (count_down,
// time_unit) via cfg_we / cfg_index / cfg_data only while the block is idle; the block
// does not enforce it. A write takes effect at the next clock edge, never read back.
//
// After its transfer is accepted, a command passes the execute state and then the finish
// state, which loads the result into the output register; a continue that does not wrap
// adds its paused time in a step between them. A read while running that does not wrap
// forms a 64-bit sum or difference in the execute state and the tick count in a further
// 64-bit step, then runs a restoring divider that produces one quotient bit per cycle,
// waits for it to finish and loads the result. Commands are handled one at a time:
// s_tready is high only while no command is in work.
// A finished result waits in the output register, so the next command is taken while the
// receiver still stalls; its result is held back until the output register is free.
//
// Reset clears the run state to ready, the start, pause and paused time to zero, the
// configuration to stopwatch with raw ticks and empties the output register.
module stopwatch_countdown_timer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// func [2:0], now [66:3], load_value [98:67], zero fill above
	input  logic [swct_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// mode [1:0], shown_value [33:2], value_valid [34], wrapped [35], accepted [36],
	// zero fill above
	output logic [swct_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                  cfg_we,
	input  logic [swct_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [swct_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic                             count_down_q;
	logic [swct_pkg::UNIT_W-1:0]      time_unit_q;
	swct_pkg::dp_cmd_t                cmd;
	swct_pkg::dp_stat_t               stat;
	swct_pkg::ctrl_res_t              res;
	logic                             res_load;
	logic                             out_free;
	logic [swct_pkg::VAL_W-1:0]       quotient;
	logic [swct_pkg::VAL_W-1:0]       shown;
	logic                             m_tvalid_q;
	logic [swct_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_down_q <= 1'b0;
			time_unit_q  <= swct_pkg::UNIT_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				swct_pkg::REG_COUNT_DOWN: count_down_q <= cfg_data[0];
				swct_pkg::REG_TIME_UNIT:  time_unit_q  <= cfg_data[swct_pkg::UNIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	swct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.func       (s_tdata[swct_pkg::FUNC_LSB +: swct_pkg::FUNC_W]),
		.count_down (count_down_q),
		.stat       (stat),
		.out_free   (out_free),
		.cmd        (cmd),
		.res        (res),
		.res_load   (res_load)
	);

	swct_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.now        (s_tdata[swct_pkg::NOW_LSB +: swct_pkg::NOW_W]),
		.load_value (s_tdata[swct_pkg::LOAD_LSB +: swct_pkg::LOAD_W]),
		.time_unit  (time_unit_q),
		.stat       (stat),
		.quotient   (quotient)
	);

	// The output register may be refilled in the cycle that its current result is taken.
	assign out_free = !m_tvalid_q || m_tready;
	// Without a reading the shown value is zero, whatever the divider holds.
	assign shown    = res.value_valid ? quotient : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_tdata_q <= swct_pkg::OUT_TDATA_W'({res.accepted, res.wrapped, res.value_valid,
			                                     shown, res.mode});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// After a transfer the command is still in work in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again straight after a transfer");

	// A reading is only ever given for an accepted command.
	a_valid_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[swct_pkg::VVALID_BIT] || m_tdata[swct_pkg::ACC_BIT]))
		else $error("reading without accepted command");

	// A backwards clock leaves the block in ready, with no reading.
	a_wrap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[swct_pkg::WRAP_BIT]) |->
		(m_tdata[swct_pkg::MODE_LSB +: swct_pkg::MODE_W] == swct_pkg::RS_READY
		 && !m_tdata[swct_pkg::VVALID_BIT]))
		else $error("wrapped result not in ready");

	// A result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!m_tvalid || m_tready))
		else $error("output register overwritten while stalled");

endmodule
